[rtl/core/dqb_pkg.sv]
// ----------------------------------------------------------------------------
// dqb_pkg
// Shared codes and constants of the DNS query builder.
// ----------------------------------------------------------------------------
package dqb_pkg;

  // input item kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_TRAILER = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LABEL    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  localparam logic [7:0] DOT_CHAR     = 8'h2e;
  localparam logic [7:0] FLAGS_HI     = 8'h01;
  localparam logic [7:0] FLAGS_LO     = 8'h00;

  localparam int unsigned HEADER_BYTES  = 12;
  localparam int unsigned TRAILER_BYTES = 5;

  typedef logic [7:0] byte_t;

endpackage

[rtl/core/dns_query_builder_core.sv]
// ----------------------------------------------------------------------------
// dns_query_builder_core
// Encodes a DNS query message as a byte stream, one transaction per byte.
// ----------------------------------------------------------------------------
// channel | signals                                         | moves
// in      | in_valid/in_ready, kind .. query_class          | one item
// out     | out_valid/out_ready, out_byte .. error_code     | one message byte
//
// One item is in work at a time; in_ready is high only between items.
// A buffered name character is taken without output; a header, a trailer or a
// label flush is sent one byte a cycle through the output register while the
// output is not stalled, with label characters fetched through the RAM read
// port.
// Reset clears the pending label and message lengths and the error; the label RAM needs no clearing pass.
// A stalled output holds its byte and the sequencer waits.
// ----------------------------------------------------------------------------
module dns_query_builder_core #(
  parameter int MESSAGE_BYTES_MAX = 512,
  parameter int LABEL_CHARS_MAX   = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] message_id,
  input  logic [15:0] question_total,
  input  logic [7:0]  name_char,
  input  logic        name_end,
  input  logic [15:0] query_type,
  input  logic [15:0] query_class,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [8:0]  byte_index,
  output logic        run_last,
  output logic [1:0]  error_code
);

  localparam int ML_W   = $clog2(MESSAGE_BYTES_MAX + 1);
  localparam int LL_W   = $clog2(LABEL_CHARS_MAX + 1);
  localparam int LA_W   = (LABEL_CHARS_MAX > 1) ? $clog2(LABEL_CHARS_MAX) : 1;
  localparam int STEP_W = (LL_W > 4) ? LL_W : 4;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_HEADER  = 4'b0010,
    ST_LABEL   = 4'b0100,
    ST_TRAILER = 4'b1000
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [LL_W-1:0]   pend_len;
  logic [LL_W-1:0]   flush_len;
  logic [ML_W-1:0]   msg_len;
  logic [1:0]        sticky;
  logic [15:0]       word_a;
  logic [15:0]       word_b;

  logic              accept;
  logic              emit;
  logic              last_byte;
  logic              overflow;
  logic              char_room;
  logic [LL_W-1:0]   pend_len_next;
  dqb_pkg::byte_t    byte_next;
  logic [1:0]        sticky_next;
  logic [8:0]        index_next;

  logic              wr_en;
  logic              rd_en;
  dqb_pkg::byte_t    rd_data;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign emit      = (state != ST_IDLE) && (!out_valid || out_ready);
  assign char_room = (pend_len < LL_W'(LABEL_CHARS_MAX));
  assign pend_len_next = pend_len + LL_W'(1);

  assign wr_en = accept && (kind == dqb_pkg::KIND_CHAR) &&
                 (name_char != dqb_pkg::DOT_CHAR) && char_room;
  assign rd_en = emit && (state == ST_LABEL) && !last_byte;

  dqb_ram #(
    .WIDTH (8),
    .DEPTH (LABEL_CHARS_MAX)
  ) u_label_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (LA_W'(pend_len)),
    .wr_data (name_char),
    .rd_en   (rd_en),
    .rd_addr (LA_W'(step)),
    .rd_data (rd_data)
  );

  always_comb begin
    byte_next = '0;
    last_byte = 1'b0;
    unique case (state)
      ST_HEADER: begin
        last_byte = (step == STEP_W'(dqb_pkg::HEADER_BYTES - 1));
        unique case (step)
          STEP_W'(0): byte_next = word_a[15:8];
          STEP_W'(1): byte_next = word_a[7:0];
          STEP_W'(2): byte_next = dqb_pkg::FLAGS_HI;
          STEP_W'(3): byte_next = dqb_pkg::FLAGS_LO;
          STEP_W'(4): byte_next = word_b[15:8];
          STEP_W'(5): byte_next = word_b[7:0];
          default:    byte_next = '0;
        endcase
      end
      ST_LABEL: begin
        last_byte = (step == STEP_W'(flush_len));
        byte_next = (step == '0) ? 8'(flush_len) : rd_data;
      end
      ST_TRAILER: begin
        last_byte = (step == STEP_W'(dqb_pkg::TRAILER_BYTES - 1));
        unique case (step)
          STEP_W'(1): byte_next = word_a[15:8];
          STEP_W'(2): byte_next = word_a[7:0];
          STEP_W'(3): byte_next = word_b[15:8];
          STEP_W'(4): byte_next = word_b[7:0];
          default:    byte_next = '0;
        endcase
      end
      default: begin
        byte_next = '0;
        last_byte = 1'b0;
      end
    endcase
  end

  always_comb begin
    overflow    = (msg_len >= ML_W'(MESSAGE_BYTES_MAX));
    sticky_next = (overflow && (sticky == dqb_pkg::ERR_NONE)) ? dqb_pkg::ERR_OVERFLOW : sticky;
    index_next  = overflow ? '0 : 9'(msg_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      pend_len  <= '0;
      msg_len   <= '0;
      sticky    <= dqb_pkg::ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        step <= '0;
        unique case (kind)
          dqb_pkg::KIND_HEADER: begin
            msg_len   <= '0;
            pend_len  <= '0;
            sticky    <= dqb_pkg::ERR_NONE;
            word_a    <= message_id;
            word_b    <= question_total;
            state     <= ST_HEADER;
          end
          dqb_pkg::KIND_CHAR: begin
            if (name_char == dqb_pkg::DOT_CHAR) begin
              flush_len <= pend_len;
              pend_len  <= '0;
              state     <= ST_LABEL;
            end else begin
              if (char_room) begin
                pend_len <= pend_len_next;
              end else if (sticky == dqb_pkg::ERR_NONE) begin
                sticky <= dqb_pkg::ERR_LABEL;
              end
              if (name_end) begin
                flush_len <= char_room ? pend_len_next : pend_len;
                pend_len  <= '0;
                state     <= ST_LABEL;
              end
            end
          end
          dqb_pkg::KIND_TRAILER: begin
            pend_len  <= '0;
            word_a    <= query_type;
            word_b    <= query_class;
            state     <= ST_TRAILER;
          end
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
        sticky    <= sticky_next;
        if (!overflow) begin
          msg_len <= msg_len + ML_W'(1);
        end
        if (last_byte) begin
          state <= ST_IDLE;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= byte_next;
      byte_index <= index_next;
      run_last   <= last_byte;
      error_code <= sticky_next;
    end
  end

endmodule

[rtl/core/dqb_ram.sv]
// ----------------------------------------------------------------------------
// dqb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/dqb_checker.sv]
// ----------------------------------------------------------------------------
// dqb_checker
// Port-level checks of the DNS query builder, bound to dns_query_builder_core.
// ----------------------------------------------------------------------------
module dqb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic [15:0] message_id,
  input logic [15:0] question_total,
  input logic [7:0]  name_char,
  input logic        name_end,
  input logic [15:0] query_type,
  input logic [15:0] query_class,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [8:0]  byte_index,
  input logic        run_last,
  input logic [1:0]  error_code
);

  a_err_code : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code == dqb_pkg::ERR_NONE || error_code == dqb_pkg::ERR_LABEL ||
                   error_code == dqb_pkg::ERR_OVERFLOW))
    else $error("error_code out of range");

  a_header_busy : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == dqb_pkg::KIND_HEADER) |=> !in_ready)
    else $error("input accepted during header run");

  a_trailer_busy : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == dqb_pkg::KIND_TRAILER) |=> !in_ready)
    else $error("input accepted during trailer run");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) &&
                                   $stable(byte_index) && $stable(run_last)))
    else $error("stalled output transaction changed");

endmodule

bind dns_query_builder_core dqb_checker u_dqb_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dns_query_builder_core. A scripted run covers the
// field extremes, empty labels, dropped labels, the label and overflow errors
// and the ignored kind. Random query messages follow, with noise and broken
// names. Every output byte is scored against a behavioral encoder, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import dqb_pkg::*;

  localparam int MSG_BYTES_MAX = 512;
  localparam int LABEL_MAX     = 63;
  localparam int RANDOM_ITEMS  = 228;
  localparam int SCRIPT_ROWS   = 27;
  localparam int DRAIN_CYCLES  = 200;
  localparam int HOLD_CYCLES   = 500;
  localparam int HOLD_AT_ITEM  = 260;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] message_id;
    logic [15:0] question_total;
    logic [7:0]  name_char;
    logic        name_end;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic        drain_first;
    logic        typed;
    logic [7:0]  t_byte;
    logic [1:0]  t_err;
  } query_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] a;
    logic [15:0] b;
    logic        name_end;
    logic [7:0]  reps;
    logic        drain;
    logic        typed;
    logic [7:0]  t_byte;
    logic [1:0]  t_err;
  } script_row_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [8:0] byte_index;
    logic       run_last;
    logic [1:0] error_code;
  } msg_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = KIND_HEADER;
  logic [15:0] message_id = '0;
  logic [15:0] question_total = '0;
  logic [7:0]  name_char = '0;
  logic        name_end = 1'b0;
  logic [15:0] query_type = '0;
  logic [15:0] query_class = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [8:0]  byte_index;
  logic        run_last;
  logic [1:0]  error_code;

  query_item_t item_feed [$];
  msg_byte_t   query_bytes_due [$];
  query_item_t cur_item;
  int          items_taken = 0;
  logic [1:0]  phase = 2'd0;
  int          fail_count = 0;

  byte_t       label_chars [LABEL_MAX];
  int          label_fill = 0;
  int          msg_fill = 0;
  logic [1:0]  sticky_err = ERR_NONE;

  int          hold_left = 0;
  logic        hold_done = 1'b0;

  dns_query_builder_core #(
    .MESSAGE_BYTES_MAX(MSG_BYTES_MAX),
    .LABEL_CHARS_MAX(LABEL_MAX)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .message_id(message_id),
    .question_total(question_total),
    .name_char(name_char),
    .name_end(name_end),
    .query_type(query_type),
    .query_class(query_class),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .byte_index(byte_index),
    .run_last(run_last),
    .error_code(error_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task put_msg_byte(input byte_t value);
    msg_byte_t b;
    b.byte_index = '0;
    if (msg_fill >= MSG_BYTES_MAX) begin
      if (sticky_err == ERR_NONE) sticky_err = ERR_OVERFLOW;
    end else begin
      b.byte_index = msg_fill[8:0];
      msg_fill++;
    end
    b.out_byte   = value;
    b.run_last   = 1'b0;
    b.error_code = sticky_err;
    query_bytes_due.push_back(b);
  endtask

  task flush_pending_label();
    int i;
    put_msg_byte(label_fill[7:0]);
    for (i = 0; i < label_fill; i++) put_msg_byte(label_chars[i]);
    label_fill = 0;
  endtask

  task encode_item(input query_item_t it);
    int first;
    int i;
    msg_byte_t b;
    first = query_bytes_due.size();
    case (it.kind)
      KIND_HEADER: begin
        msg_fill   = 0;
        label_fill = 0;
        sticky_err = ERR_NONE;
        put_msg_byte(it.message_id[15:8]);
        put_msg_byte(it.message_id[7:0]);
        put_msg_byte(FLAGS_HI);
        put_msg_byte(FLAGS_LO);
        put_msg_byte(it.question_total[15:8]);
        put_msg_byte(it.question_total[7:0]);
        for (i = 0; i < 6; i++) put_msg_byte(8'h00);
      end
      KIND_CHAR: begin
        if (it.name_char == DOT_CHAR) begin
          flush_pending_label();
        end else begin
          if (label_fill < LABEL_MAX) begin
            label_chars[label_fill] = it.name_char;
            label_fill++;
          end else if (sticky_err == ERR_NONE) begin
            sticky_err = ERR_LABEL;
          end
          if (it.name_end) flush_pending_label();
        end
      end
      KIND_TRAILER: begin
        label_fill = 0;
        put_msg_byte(8'h00);
        put_msg_byte(it.query_type[15:8]);
        put_msg_byte(it.query_type[7:0]);
        put_msg_byte(it.query_class[15:8]);
        put_msg_byte(it.query_class[7:0]);
      end
      default: ;
    endcase
    if (query_bytes_due.size() > first) begin
      b = query_bytes_due.pop_back();
      b.run_last = 1'b1;
      if (it.typed) begin
        b.out_byte   = it.t_byte;
        b.error_code = it.t_err;
      end
      query_bytes_due.push_back(b);
    end
  endtask

  task check_byte();
    msg_byte_t due;
    if (query_bytes_due.size() == 0) begin
      $error("unexpected transaction: out_byte %0h byte_index %0d", out_byte, byte_index);
      fail_count++;
    end else begin
      due = query_bytes_due.pop_front();
      if (out_byte !== due.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", due.out_byte, out_byte);
        fail_count++;
      end
      if (byte_index !== due.byte_index) begin
        $error("byte_index: expected %0d, actual %0d", due.byte_index, byte_index);
        fail_count++;
      end
      if (run_last !== due.run_last) begin
        $error("run_last: expected %0b, actual %0b", due.run_last, run_last);
        fail_count++;
      end
      if (error_code !== due.error_code) begin
        $error("error_code: expected %0d, actual %0d", due.error_code, error_code);
        fail_count++;
      end
    end
  endtask

  function automatic query_item_t make_item(input logic [1:0] k);
    query_item_t it;
    it.kind           = k;
    it.message_id     = 16'($urandom);
    it.question_total = 16'($urandom);
    it.name_char      = 8'($urandom_range(0, 255));
    it.name_end       = 1'($urandom_range(0, 1));
    it.query_type     = 16'($urandom);
    it.query_class    = 16'($urandom);
    it.drain_first    = 1'b0;
    it.typed          = 1'b0;
    it.t_byte         = 8'h00;
    it.t_err          = ERR_NONE;
    return it;
  endfunction

  function automatic byte_t label_char();
    byte_t c;
    c = 8'($urandom_range(0, 255));
    if (c == DOT_CHAR) c = c ^ 8'h01;
    return c;
  endfunction

  function automatic int pick_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(60, 70);
    return $urandom_range(1, 12);
  endfunction

  function automatic script_row_t script_at(input int n);
    case (n)
      0:  return '{KIND_CHAR,    16'h0071, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      1:  return '{KIND_CHAR,    16'h002e, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      2:  return '{KIND_UNUSED,  16'hffff, 16'hffff, 1'b1, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      3:  return '{KIND_HEADER,  16'hffff, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b1, 8'h00, ERR_NONE};
      4:  return '{KIND_HEADER,  16'h0000, 16'hffff, 1'b0, 8'd1,   1'b0, 1'b1, 8'h00, ERR_NONE};
      5:  return '{KIND_CHAR,    16'h0077, 16'h0000, 1'b0, 8'd3,   1'b0, 1'b0, 8'h00, ERR_NONE};
      6:  return '{KIND_CHAR,    16'h002e, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      7:  return '{KIND_CHAR,    16'h002e, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b1, 8'h00, ERR_NONE};
      8:  return '{KIND_CHAR,    16'h0000, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      9:  return '{KIND_CHAR,    16'h00ff, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      10: return '{KIND_CHAR,    16'h0063, 16'h0000, 1'b1, 8'd1,   1'b0, 1'b1, 8'h63, ERR_NONE};
      11: return '{KIND_CHAR,    16'h0078, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      12: return '{KIND_CHAR,    16'h002e, 16'h0000, 1'b1, 8'd1,   1'b0, 1'b1, 8'h78, ERR_NONE};
      13: return '{KIND_CHAR,    16'h0070, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      14: return '{KIND_TRAILER, 16'hffff, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b1, 8'h00, ERR_NONE};
      15: return '{KIND_TRAILER, 16'h0000, 16'hffff, 1'b0, 8'd1,   1'b0, 1'b1, 8'hff, ERR_NONE};
      16: return '{KIND_CHAR,    16'h002e, 16'h0000, 1'b1, 8'd1,   1'b0, 1'b1, 8'h00, ERR_NONE};
      17: return '{KIND_HEADER,  16'h1234, 16'h0001, 1'b0, 8'd1,   1'b1, 1'b0, 8'h00, ERR_NONE};
      18: return '{KIND_CHAR,    16'h0078, 16'h0000, 1'b0, 8'd64,  1'b0, 1'b0, 8'h00, ERR_NONE};
      19: return '{KIND_CHAR,    16'h0079, 16'h0000, 1'b1, 8'd1,   1'b0, 1'b1, 8'h78, ERR_LABEL};
      20: return '{KIND_TRAILER, 16'h0001, 16'h0001, 1'b0, 8'd1,   1'b0, 1'b1, 8'h01, ERR_LABEL};
      21: return '{KIND_HEADER,  16'h00ab, 16'h0001, 1'b0, 8'd1,   1'b0, 1'b1, 8'h00, ERR_NONE};
      22: return '{KIND_TRAILER, 16'h0001, 16'h1234, 1'b0, 8'd101, 1'b0, 1'b1, 8'h34, ERR_OVERFLOW};
      23: return '{KIND_CHAR,    16'h002e, 16'h0000, 1'b0, 8'd1,   1'b0, 1'b1, 8'h00, ERR_OVERFLOW};
      24: return '{KIND_HEADER,  16'h5a5a, 16'h0002, 1'b0, 8'd1,   1'b1, 1'b1, 8'h00, ERR_NONE};
      25: return '{KIND_CHAR,    16'h007a, 16'h0000, 1'b1, 8'd1,   1'b0, 1'b0, 8'h00, ERR_NONE};
      default: return '{KIND_TRAILER, 16'h001c, 16'h0001, 1'b0, 8'd1, 1'b0, 1'b1, 8'h01, ERR_NONE};
    endcase
  endfunction

  task build_script();
    script_row_t row;
    query_item_t it;
    int r;
    int k;
    for (r = 0; r < SCRIPT_ROWS; r++) begin
      row = script_at(r);
      for (k = 0; k < row.reps; k++) begin
        it = make_item(row.kind);
        case (row.kind)
          KIND_HEADER: begin
            it.message_id     = row.a;
            it.question_total = row.b;
          end
          KIND_CHAR: begin
            it.name_char = row.a[7:0];
            it.name_end  = row.name_end && (k == row.reps - 1);
          end
          KIND_TRAILER: begin
            it.query_type  = row.a;
            it.query_class = row.b;
          end
          default: ;
        endcase
        it.drain_first = row.drain && (k == 0);
        it.typed       = row.typed && (k == row.reps - 1);
        it.t_byte      = row.t_byte;
        it.t_err       = row.t_err;
        item_feed.push_back(it);
      end
    end
  endtask

  task build_random();
    query_item_t it;
    int n;
    int seq;
    int roll;
    int q;
    int questions;
    int l;
    int labels;
    int c;
    int len;
    logic dot_end;
    n   = 0;
    seq = 0;
    while (n < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        it = make_item(KIND_HEADER);
        it.drain_first = (seq % 10 == 9);
        item_feed.push_back(it);
        n++;
        seq++;
        questions = $urandom_range(1, 3);
        for (q = 0; q < questions; q++) begin
          labels = $urandom_range(1, 4);
          for (l = 0; l < labels; l++) begin
            len     = pick_label_len();
            dot_end = (l == labels - 1) && (len == 0 || $urandom_range(0, 4) == 0);
            for (c = 0; c < len; c++) begin
              it = make_item(KIND_CHAR);
              it.name_char = label_char();
              it.name_end  = (l == labels - 1) && (c == len - 1) && !dot_end;
              item_feed.push_back(it);
              n++;
            end
            if (l != labels - 1 || dot_end) begin
              it = make_item(KIND_CHAR);
              it.name_char = DOT_CHAR;
              it.name_end  = dot_end;
              item_feed.push_back(it);
              n++;
            end
          end
          item_feed.push_back(make_item(KIND_TRAILER));
          n++;
        end
      end else if (roll < 90) begin
        repeat ($urandom_range(1, 4)) begin
          it = make_item(2'($urandom_range(0, 3)));
          item_feed.push_back(it);
          if (it.kind != KIND_UNUSED) n++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          it = make_item(KIND_CHAR);
          it.name_char = label_char();
          it.name_end  = 1'b0;
          item_feed.push_back(it);
          n++;
        end
        item_feed.push_back(make_item($urandom_range(0, 1) ? KIND_TRAILER : KIND_HEADER));
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_byte();
      if (in_valid && in_ready) begin
        encode_item(cur_item);
        items_taken <= items_taken + 1;
      end
      phase <= 2'((items_taken / 50) % 4);
      if (!in_valid || in_ready) begin
        if (item_feed.size() != 0
            && !(item_feed[0].drain_first && query_bytes_due.size() != 0)
            && !((phase == 2'd1 && $urandom_range(0, 99) < 57)
                 || (phase == 2'd3 && $urandom_range(0, 99) < 31))) begin
          cur_item       = item_feed.pop_front();
          kind           <= cur_item.kind;
          message_id     <= cur_item.message_id;
          question_total <= cur_item.question_total;
          name_char      <= cur_item.name_char;
          name_end       <= cur_item.name_end;
          query_type     <= cur_item.query_type;
          query_class    <= cur_item.query_class;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !((phase == 2'd2 && $urandom_range(0, 99) < 57)
                     || (phase == 2'd3 && $urandom_range(0, 99) < 31));
    end
  end

  initial begin
    build_script();
    build_random();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (item_feed.size() != 0 || in_valid || query_bytes_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && query_bytes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[dns_query_builder_core.f]
rtl/core/dqb_pkg.sv
rtl/core/dqb_ram.sv
rtl/core/dns_query_builder_core.sv
rtl/core/dqb_checker.sv
tb/sv/tb_top.sv
